[design/rlpt_pkg.sv]
// ----------------------------------------------------------------------------
// rlpt_pkg
// Shared constants, types and helper functions for the lidar point transform.
// ----------------------------------------------------------------------------
package rlpt_pkg;

   localparam int CORDIC_STEPS  = 24;
   localparam int FRACTION_BITS = 16;
   localparam int DATA_W        = 64;
   localparam int ANGLE_W       = 32;
   localparam int COORD_W       = 32;
   localparam int RESID_W       = 34;
   localparam int GAIN_W        = 30;
   localparam int PROD_W        = COORD_W + GAIN_W;
   localparam int INDEX_W       = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'h26DD3B6A;

   localparam logic [INDEX_W-1:0] REG_TILT_ONE    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_JOINT_TWO   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_TILT_TWO    = 3'd2;
   localparam logic [INDEX_W-1:0] REG_LENGTH_ONE  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_OFFSET_ONE  = 3'd4;
   localparam logic [INDEX_W-1:0] REG_LENGTH_TWO  = 3'd5;
   localparam logic [INDEX_W-1:0] REG_OFFSET_TWO  = 3'd6;

   typedef struct packed {
      logic signed [DATA_W-1:0]  a;
      logic signed [DATA_W-1:0]  b;
      logic signed [DATA_W-1:0]  c;
      logic        [ANGLE_W-1:0] carry;
   } vec_type;

   // Q16.16 word to wide internal format with guard bits below the LSB
   function automatic logic signed [DATA_W-1:0] widen(input logic [COORD_W-1:0] raw);
      logic signed [DATA_W-1:0] ext;
      ext = DATA_W'(signed'(raw));
      return ext <<< FRACTION_BITS;
   endfunction

   function automatic logic [ANGLE_W-1:0] cordic_atan(input logic [4:0] idx);
      logic [ANGLE_W-1:0] t;
      case (idx)
         5'd0:  t = 32'd536870912;
         5'd1:  t = 32'd316933406;
         5'd2:  t = 32'd167458907;
         5'd3:  t = 32'd85004756;
         5'd4:  t = 32'd42667331;
         5'd5:  t = 32'd21354465;
         5'd6:  t = 32'd10679838;
         5'd7:  t = 32'd5340245;
         5'd8:  t = 32'd2670163;
         5'd9:  t = 32'd1335087;
         5'd10: t = 32'd667544;
         5'd11: t = 32'd333772;
         5'd12: t = 32'd166886;
         5'd13: t = 32'd83443;
         5'd14: t = 32'd41722;
         5'd15: t = 32'd20861;
         5'd16: t = 32'd10430;
         5'd17: t = 32'd5215;
         5'd18: t = 32'd2608;
         5'd19: t = 32'd1304;
         5'd20: t = 32'd652;
         5'd21: t = 32'd326;
         5'd22: t = 32'd163;
         5'd23: t = 32'd81;
         5'd24: t = 32'd41;
         5'd25: t = 32'd20;
         5'd26: t = 32'd10;
         5'd27: t = 32'd5;
         5'd28: t = 32'd3;
         5'd29: t = 32'd1;
         5'd30: t = 32'd1;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

[design/rlpt_front.sv]
// ----------------------------------------------------------------------------
// rlpt_front
// Input stage: takes a point transaction and widens it to the internal format.
// ----------------------------------------------------------------------------
module rlpt_front import rlpt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ANGLE_W-1:0]  req_encoder_angle,
   input  logic [COORD_W-1:0]  req_point_x,
   input  logic [COORD_W-1:0]  req_point_y,
   input  logic [COORD_W-1:0]  req_point_z,
   output logic                push,
   input  logic                queue_full,
   output vec_type             push_data
);

   logic    valid_ff, valid_in;
   vec_type data_ff, data_in;
   logic    take;

   assign push      = valid_ff && !queue_full;
   assign req_ready = !valid_ff || push;
   assign take      = req_valid && req_ready;
   assign push_data = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in      = 1'b1;
         data_in.a     = widen(req_point_x);
         data_in.b     = widen(req_point_y);
         data_in.c     = widen(req_point_z);
         data_in.carry = req_encoder_angle;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

[design/rlpt_queue.sv]
// ----------------------------------------------------------------------------
// rlpt_queue
// Short queue between the input stage and the transform pipeline.
// ----------------------------------------------------------------------------
module rlpt_queue import rlpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  vec_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output vec_type pop_data
);

   vec_type     slot_ff [QUEUE_DEPTH];
   logic [1:0]  count_ff, count_in;
   logic        rd_ff, rd_in, wr_ff, wr_in;
   logic        do_pop;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      if (push) begin
         wr_in = !wr_ff;
      end
      if (do_pop) begin
         rd_in = !rd_ff;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[design/rlpt_rotator.sv]
// ----------------------------------------------------------------------------
// rlpt_rotator
// Pipelined gain-corrected CORDIC rotation of the (a, b) pair; c and carry
// travel alongside.
// ----------------------------------------------------------------------------
module rlpt_rotator import rlpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  vec_type            in_data,
   input  logic [ANGLE_W-1:0] in_angle,
   output logic               out_valid,
   output vec_type            out_data
);

   typedef struct packed {
      logic signed [DATA_W-1:0]  a;
      logic signed [DATA_W-1:0]  b;
      logic signed [RESID_W-1:0] z;
      logic        [DATA_W-1:0]  c;
      logic        [ANGLE_W-1:0] carry;
   } step_type;

   typedef struct packed {
      logic [DATA_W-1:0]  ma;
      logic [DATA_W-1:0]  mb;
      logic               na;
      logic               nb;
      logic [DATA_W-1:0]  c;
      logic [ANGLE_W-1:0] carry;
   } mag_type;

   typedef struct packed {
      logic [PROD_W-1:0]  a_hi;
      logic [PROD_W-1:0]  a_lo;
      logic [PROD_W-1:0]  b_hi;
      logic [PROD_W-1:0]  b_lo;
      logic               na;
      logic               nb;
      logic [DATA_W-1:0]  c;
      logic [ANGLE_W-1:0] carry;
   } prod_type;

   step_type st_ff [CORDIC_STEPS+1];
   step_type st_in [CORDIC_STEPS+1];
   logic     sv_ff [CORDIC_STEPS+1];

   mag_type  mag_ff, mag_in;
   prod_type prod_ff, prod_in;
   mag_type  sum_ff, sum_in;
   vec_type  out_ff, out_in;
   logic     mag_v_ff, prod_v_ff, sum_v_ff, out_v_ff;

   // fold the angle into the right half-plane
   always_comb begin
      logic [ANGLE_W-1:0] ang;
      logic               flip;
      flip = (in_angle[31:30] == 2'b01) || (in_angle[31:30] == 2'b10);
      ang  = flip ? {~in_angle[31], in_angle[30:0]} : in_angle;
      st_in[0].a     = flip ? -in_data.a : in_data.a;
      st_in[0].b     = flip ? -in_data.b : in_data.b;
      st_in[0].z     = RESID_W'(signed'(ang));
      st_in[0].c     = in_data.c;
      st_in[0].carry = in_data.carry;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_comb begin
         logic signed [DATA_W-1:0]  dx;
         logic signed [DATA_W-1:0]  dy;
         logic signed [RESID_W-1:0] t;
         dx = st_ff[i].b >>> i;
         dy = st_ff[i].a >>> i;
         t  = RESID_W'(cordic_atan(5'(i)));
         st_in[i+1] = st_ff[i];
         if (!st_ff[i].z[RESID_W-1]) begin
            st_in[i+1].a = st_ff[i].a - dx;
            st_in[i+1].b = st_ff[i].b + dy;
            st_in[i+1].z = st_ff[i].z - t;
         end else begin
            st_in[i+1].a = st_ff[i].a + dx;
            st_in[i+1].b = st_ff[i].b - dy;
            st_in[i+1].z = st_ff[i].z + t;
         end
      end
   end

   // gain correction: magnitude, partial products, sum, sign
   always_comb begin
      logic signed [DATA_W-1:0] fa, fb;
      fa = st_ff[CORDIC_STEPS].a;
      fb = st_ff[CORDIC_STEPS].b;
      mag_in.na    = fa[DATA_W-1];
      mag_in.nb    = fb[DATA_W-1];
      mag_in.ma    = fa[DATA_W-1] ? DATA_W'(-fa) : DATA_W'(fa);
      mag_in.mb    = fb[DATA_W-1] ? DATA_W'(-fb) : DATA_W'(fb);
      mag_in.c     = st_ff[CORDIC_STEPS].c;
      mag_in.carry = st_ff[CORDIC_STEPS].carry;
   end

   always_comb begin
      prod_in.a_hi  = mag_ff.ma[63:32] * GAIN_Q30;
      prod_in.a_lo  = mag_ff.ma[31:0]  * GAIN_Q30;
      prod_in.b_hi  = mag_ff.mb[63:32] * GAIN_Q30;
      prod_in.b_lo  = mag_ff.mb[31:0]  * GAIN_Q30;
      prod_in.na    = mag_ff.na;
      prod_in.nb    = mag_ff.nb;
      prod_in.c     = mag_ff.c;
      prod_in.carry = mag_ff.carry;
   end

   always_comb begin
      logic [PROD_W:0] ra, rb;
      ra = {1'b0, prod_ff.a_lo} + (PROD_W+1)'(1 << 29);
      rb = {1'b0, prod_ff.b_lo} + (PROD_W+1)'(1 << 29);
      sum_in.ma    = {prod_ff.a_hi, 2'b00} + DATA_W'(ra[PROD_W:30]);
      sum_in.mb    = {prod_ff.b_hi, 2'b00} + DATA_W'(rb[PROD_W:30]);
      sum_in.na    = prod_ff.na;
      sum_in.nb    = prod_ff.nb;
      sum_in.c     = prod_ff.c;
      sum_in.carry = prod_ff.carry;
   end

   always_comb begin
      out_in.a     = sum_ff.na ? -signed'(sum_ff.ma) : signed'(sum_ff.ma);
      out_in.b     = sum_ff.nb ? -signed'(sum_ff.mb) : signed'(sum_ff.mb);
      out_in.c     = signed'(sum_ff.c);
      out_in.carry = sum_ff.carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            sv_ff[k] <= 1'b0;
         end
         mag_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         sum_v_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= in_valid;
         for (int k = 1; k <= CORDIC_STEPS; k++) begin
            sv_ff[k] <= sv_ff[k-1];
         end
         mag_v_ff  <= sv_ff[CORDIC_STEPS];
         prod_v_ff <= mag_v_ff;
         sum_v_ff  <= prod_v_ff;
         out_v_ff  <= sum_v_ff;
      end
      if (adv) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

[design/rotating_lidar_point_transform_top.sv]
// ----------------------------------------------------------------------------
// rotating_lidar_point_transform_top
// Maps a lidar point and its encoder angle into the base frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one point (Q16.16 x, y, z) and the encoder binary angle;
//   rsp_* returns the base-frame point, saturated, with an overflow flag.
//   Both channels use valid/ready; one result per request, in order.
//   csr_we/csr_index/csr_wdata write the seven link registers; write them
//   only while no transaction is in flight. Indexes beyond six are ignored.
// Throughput: one point per clock while rsp_ready does not stall the output.
//   Results reach rsp_valid through the four CORDIC pipelines
//   (one micro-rotation per stage, then a split 32x30 gain multiply).
// Reset clears all valid state and the registers to zero.
// When the receiver stalls, the whole transform pipeline holds; the input
//   stage and the two-entry queue in front of it go on taking requests
//   until full, then req_ready drops.
// ----------------------------------------------------------------------------
module rotating_lidar_point_transform_top import rlpt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ANGLE_W-1:0]  req_encoder_angle,
   input  logic [COORD_W-1:0]  req_point_x,
   input  logic [COORD_W-1:0]  req_point_y,
   input  logic [COORD_W-1:0]  req_point_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COORD_W-1:0]  rsp_base_x,
   output logic [COORD_W-1:0]  rsp_base_y,
   output logic [COORD_W-1:0]  rsp_base_z,
   output logic                rsp_overflow,
   input  logic                csr_we,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [ANGLE_W-1:0]  csr_wdata
);

   logic [ANGLE_W-1:0] tilt1_ff, joint2_ff, tilt2_ff;
   logic [COORD_W-1:0] len1_ff, off1_ff, len2_ff, off2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt1_ff  <= '0;
         joint2_ff <= '0;
         tilt2_ff  <= '0;
         len1_ff   <= '0;
         off1_ff   <= '0;
         len2_ff   <= '0;
         off2_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_TILT_ONE:   tilt1_ff  <= csr_wdata;
            REG_JOINT_TWO:  joint2_ff <= csr_wdata;
            REG_TILT_TWO:   tilt2_ff  <= csr_wdata;
            REG_LENGTH_ONE: len1_ff   <= csr_wdata;
            REG_OFFSET_ONE: off1_ff   <= csr_wdata;
            REG_LENGTH_TWO: len2_ff   <= csr_wdata;
            REG_OFFSET_TWO: off2_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic    adv;
   logic    push, queue_full, queue_ne;
   vec_type push_data, pop_data;

   logic    rsp_valid_ff;
   logic [COORD_W-1:0] bx_ff, by_ff, bz_ff;
   logic    ovf_ff;

   assign adv = !rsp_valid_ff || rsp_ready;

   rlpt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_encoder_angle (req_encoder_angle),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_z       (req_point_z),
      .push              (push),
      .queue_full        (queue_full),
      .push_data         (push_data)
   );

   rlpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (adv),
      .not_empty (queue_ne),
      .pop_data  (pop_data)
   );

   // rotation 1: (y, z) by tilt two; x and encoder angle ride along
   vec_type r1_in, r1_out;
   logic    r1_v;
   assign r1_in.a     = pop_data.b;
   assign r1_in.b     = pop_data.c;
   assign r1_in.c     = pop_data.a;
   assign r1_in.carry = pop_data.carry;

   rlpt_rotator u_rot1 (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (queue_ne), .in_data (r1_in), .in_angle (tilt2_ff),
      .out_valid (r1_v), .out_data (r1_out)
   );

   // add second link offsets: x += a2, z += d2
   vec_type o1_ff, o1_in;
   logic    o1_v_ff;
   always_comb begin
      o1_in.a     = r1_out.c + widen(len2_ff);
      o1_in.b     = r1_out.a;
      o1_in.c     = r1_out.b + widen(off2_ff);
      o1_in.carry = r1_out.carry;
   end

   // rotation 2: (x, y) by joint two
   vec_type r2_out, r3_in, r3_out;
   logic    r2_v, r3_v;

   rlpt_rotator u_rot2 (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (o1_v_ff), .in_data (o1_ff), .in_angle (joint2_ff),
      .out_valid (r2_v), .out_data (r2_out)
   );

   // rotation 3: (y, z) by tilt one
   assign r3_in.a     = r2_out.b;
   assign r3_in.b     = r2_out.c;
   assign r3_in.c     = r2_out.a;
   assign r3_in.carry = r2_out.carry;

   rlpt_rotator u_rot3 (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (r2_v), .in_data (r3_in), .in_angle (tilt1_ff),
      .out_valid (r3_v), .out_data (r3_out)
   );

   // add first link offsets: x += a1, z += d1
   vec_type o2_ff, o2_in, r4_out;
   logic    o2_v_ff, r4_v;
   always_comb begin
      o2_in.a     = r3_out.c + widen(len1_ff);
      o2_in.b     = r3_out.a;
      o2_in.c     = r3_out.b + widen(off1_ff);
      o2_in.carry = r3_out.carry;
   end

   // rotation 4: (x, y) by the encoder angle
   rlpt_rotator u_rot4 (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (o2_v_ff), .in_data (o2_ff), .in_angle (o2_ff.carry),
      .out_valid (r4_v), .out_data (r4_out)
   );

   // drop guard bits with rounding, saturate to 32 bits
   logic [COORD_W-1:0] bx_in, by_in, bz_in;
   logic               sx, sy, sz;

   function automatic logic [COORD_W:0] narrow(input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] t;
      logic signed [DATA_W-1:0] r;
      logic                     sat;
      logic [COORD_W-1:0]       q;
      t   = v + (DATA_W'(1) <<< (FRACTION_BITS - 1));
      r   = t >>> FRACTION_BITS;
      sat = (r[DATA_W-1:COORD_W-1] != '0) && (r[DATA_W-1:COORD_W-1] != '1);
      if (!sat) begin
         q = r[COORD_W-1:0];
      end else if (r[DATA_W-1]) begin
         q = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         q = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return {sat, q};
   endfunction

   assign {sx, bx_in} = narrow(r4_out.a);
   assign {sy, by_in} = narrow(r4_out.b);
   assign {sz, bz_in} = narrow(r4_out.c);

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_v_ff      <= 1'b0;
         o2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         o1_v_ff      <= r1_v;
         o2_v_ff      <= r3_v;
         rsp_valid_ff <= r4_v;
      end
      if (adv) begin
         o1_ff  <= o1_in;
         o2_ff  <= o2_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         bz_ff  <= bz_in;
         ovf_ff <= sx || sy || sz;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_base_x   = bx_ff;
   assign rsp_base_y   = by_ff;
   assign rsp_base_z   = bz_ff;
   assign rsp_overflow = ovf_ff;

endmodule
